// File: design/isi_pkg.sv
// Shared types, constants and helpers for the identifier scanner and symbol table.
package isi_pkg;

    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int MAX_NAME_LEN_DEF = 32;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A       = 8'h61;
    localparam logic [7:0] CH_LO_Z       = 8'h7A;
    localparam logic [7:0] CH_UP_A       = 8'h41;
    localparam logic [7:0] CH_UP_Z       = 8'h5A;
    localparam logic [7:0] CH_DIG_0      = 8'h30;
    localparam logic [7:0] CH_DIG_9      = 8'h39;

    typedef enum logic [1:0] {
        CLS_UNDERSCORE = 2'd0,
        CLS_LETTER     = 2'd1,
        CLS_DIGIT      = 2'd2,
        CLS_OTHER      = 2'd3
    } char_class_t;

    typedef enum logic [1:0] {
        RES_FOUND = 2'd0,
        RES_NEW   = 2'd1,
        RES_FULL  = 2'd2
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LEN_CHK,
        ST_CH_RD,
        ST_CH_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic      scan_en;
        logic      idx_clr;
        logic      idx_inc;
        logic      ch_clr;
        logic      ch_inc;
        logic      len_rd;
        logic      ch_rd;
        logic      copy_wr;
        logic      len_wr;
        logic      kind_we;
        res_kind_t kind;
        logic      out_load;
    } isi_cmd_t;

    typedef struct packed {
        logic fin;
        logic idx_end;
        logic full;
        logic len_eq;
        logic ch_eq;
        logic ch_last;
        logic out_free;
    } isi_sts_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        if (c == CH_UNDERSCORE) begin
            r = CLS_UNDERSCORE;
        end else if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
            r = CLS_LETTER;
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            r = CLS_DIGIT;
        end else begin
            r = CLS_OTHER;
        end
        return r;
    endfunction

endpackage

// File: design/isi_ctrl.sv
// Sequencer for scanning, table search, append and result hand-off.
module isi_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  isi_pkg::isi_sts_t  sts,
    output isi_pkg::isi_cmd_t  cmd
);

    isi_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= isi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            isi_pkg::ST_IDLE: begin
                if (s_tvalid && sts.fin) state_next = isi_pkg::ST_SEARCH;
            end
            isi_pkg::ST_SEARCH: begin
                if (!sts.idx_end)      state_next = isi_pkg::ST_LEN_CHK;
                else if (sts.full)     state_next = isi_pkg::ST_RESULT;
                else                   state_next = isi_pkg::ST_COPY_RD;
            end
            isi_pkg::ST_LEN_CHK: begin
                state_next = sts.len_eq ? isi_pkg::ST_CH_RD : isi_pkg::ST_SEARCH;
            end
            isi_pkg::ST_CH_RD: state_next = isi_pkg::ST_CH_CHK;
            isi_pkg::ST_CH_CHK: begin
                if (!sts.ch_eq)       state_next = isi_pkg::ST_SEARCH;
                else if (sts.ch_last) state_next = isi_pkg::ST_RESULT;
                else                  state_next = isi_pkg::ST_CH_RD;
            end
            isi_pkg::ST_COPY_RD: state_next = isi_pkg::ST_COPY_WR;
            isi_pkg::ST_COPY_WR: begin
                state_next = sts.ch_last ? isi_pkg::ST_RESULT : isi_pkg::ST_COPY_RD;
            end
            isi_pkg::ST_RESULT: begin
                if (sts.out_free) state_next = isi_pkg::ST_IDLE;
            end
            default: state_next = isi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.kind = isi_pkg::RES_FOUND;
        s_tready = 1'b0;
        unique case (state_reg)
            isi_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.scan_en = s_tvalid;
                cmd.idx_clr = 1'b1;
            end
            isi_pkg::ST_SEARCH: begin
                cmd.ch_clr = 1'b1;
                if (!sts.idx_end) begin
                    cmd.len_rd = 1'b1;
                end else if (sts.full) begin
                    cmd.kind_we = 1'b1;
                    cmd.kind    = isi_pkg::RES_FULL;
                end
            end
            isi_pkg::ST_LEN_CHK: begin
                cmd.ch_clr  = 1'b1;
                cmd.idx_inc = !sts.len_eq;
            end
            isi_pkg::ST_CH_RD: cmd.ch_rd = 1'b1;
            isi_pkg::ST_CH_CHK: begin
                if (!sts.ch_eq) begin
                    cmd.idx_inc = 1'b1;
                end else if (sts.ch_last) begin
                    cmd.kind_we = 1'b1;
                    cmd.kind    = isi_pkg::RES_FOUND;
                end else begin
                    cmd.ch_inc = 1'b1;
                end
            end
            isi_pkg::ST_COPY_RD: cmd.ch_rd = 1'b1;
            isi_pkg::ST_COPY_WR: begin
                cmd.copy_wr = 1'b1;
                cmd.ch_inc  = 1'b1;
                if (sts.ch_last) begin
                    cmd.len_wr  = 1'b1;
                    cmd.kind_we = 1'b1;
                    cmd.kind    = isi_pkg::RES_NEW;
                end
            end
            isi_pkg::ST_RESULT: cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

endmodule

// File: design/isi_dp.sv
// Scanner registers, name buffer, symbol table memories and result register.
module isi_dp #(
    parameter int TABLE_DEPTH  = isi_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_NAME_LEN = isi_pkg::MAX_NAME_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        char_code,
    input  logic              end_of_input,
    input  isi_pkg::isi_cmd_t cmd,
    output isi_pkg::isi_sts_t sts,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [23:0]       m_tdata
);

    localparam int IDW = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(MAX_NAME_LEN);
    localparam int LW  = $clog2(MAX_NAME_LEN + 1);
    localparam int EW  = IDW + CW;

    logic [7:0]    name_mem [MAX_NAME_LEN];
    logic [7:0]    ent_mem  [2**EW];
    logic [LW-1:0] lens_mem [TABLE_DEPTH];

    logic            in_id_reg;
    logic [LW-1:0]   len_reg;
    logic            ovf_reg;
    logic [IDW:0]    count_reg;
    logic [IDW:0]    idx_reg;
    logic [CW-1:0]   ch_reg;
    logic [7:0]      name_q_reg;
    logic [7:0]      ent_q_reg;
    logic [LW-1:0]   lenq_reg;
    logic [IDW-1:0]  id_reg;
    logic            new_reg;
    logic            full_reg;
    logic            m_valid_reg;
    logic [23:0]     m_data_reg;

    isi_pkg::char_class_t cls;
    logic          id_char;
    logic [LW-1:0] len_eff;

    assign cls     = isi_pkg::classify(char_code);
    assign id_char = (cls == isi_pkg::CLS_LETTER) || (cls == isi_pkg::CLS_UNDERSCORE)
                     || (in_id_reg && cls == isi_pkg::CLS_DIGIT);
    assign len_eff = in_id_reg ? len_reg : '0;

    assign sts.fin      = in_id_reg && (end_of_input || cls == isi_pkg::CLS_OTHER);
    assign sts.idx_end  = (idx_reg == count_reg);
    assign sts.full     = (count_reg == (IDW+1)'(TABLE_DEPTH));
    assign sts.len_eq   = (lenq_reg == len_reg);
    assign sts.ch_eq    = (name_q_reg == ent_q_reg);
    assign sts.ch_last  = (LW'(ch_reg) + LW'(1) == len_reg);
    assign sts.out_free = !m_valid_reg || m_tready;

    // scanner control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_id_reg <= 1'b0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.scan_en) begin
            if (end_of_input || !id_char) begin
                in_id_reg <= 1'b0;
                if (!in_id_reg) begin
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                end
            end else begin
                in_id_reg <= 1'b1;
                if (len_eff < LW'(MAX_NAME_LEN)) begin
                    len_reg <= len_eff + LW'(1);
                    ovf_reg <= in_id_reg && ovf_reg;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_en && !end_of_input && id_char && len_eff < LW'(MAX_NAME_LEN)) begin
            name_mem[len_eff[CW-1:0]] <= char_code;
        end
        if (cmd.ch_rd) begin
            name_q_reg <= name_mem[ch_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.copy_wr) begin
            ent_mem[{count_reg[IDW-1:0], ch_reg}] <= name_q_reg;
        end
        if (cmd.ch_rd) begin
            ent_q_reg <= ent_mem[{idx_reg[IDW-1:0], ch_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.len_wr) begin
            lens_mem[count_reg[IDW-1:0]] <= len_reg;
        end
        if (cmd.len_rd) begin
            lenq_reg <= lens_mem[idx_reg[IDW-1:0]];
        end
    end

    // search counters and table fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
            ch_reg    <= '0;
        end else begin
            if (cmd.len_wr)       count_reg <= count_reg + (IDW+1)'(1);
            if (cmd.idx_clr)      idx_reg   <= '0;
            else if (cmd.idx_inc) idx_reg   <= idx_reg + (IDW+1)'(1);
            if (cmd.ch_clr)       ch_reg    <= '0;
            else if (cmd.ch_inc)  ch_reg    <= ch_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.kind_we) begin
            unique case (cmd.kind)
                isi_pkg::RES_FOUND: id_reg <= idx_reg[IDW-1:0];
                isi_pkg::RES_NEW:   id_reg <= count_reg[IDW-1:0];
                default:            id_reg <= '0;
            endcase
            new_reg  <= (cmd.kind == isi_pkg::RES_NEW);
            full_reg <= (cmd.kind == isi_pkg::RES_FULL);
        end
    end

    // result register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {7'd0, 6'(len_reg), ovf_reg, full_reg, new_reg,
                           8'(32'(id_reg))};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: design/identifier_scanner_symbol_intern.sv
// Top level: identifier scanner with symbol table interning.
//
//  channel | ports                    | payload
//  --------+--------------------------+----------------------------------------------
//  input   | s_tvalid/s_tready        | tdata char_code[7:0], tuser end_of_input
//  result  | m_tvalid/m_tready        | tdata id, is_new, full, truncated, length
//
// A character that does not end a name is taken without a search. A finished
// name runs a linear search: each stored entry's length is compared, and on a
// match its characters one by one; a name not found is appended if the table has
// room, one character at a time. Input is held off until the result register is
// loaded.
// Reset clears scanner, counters and result valid; the table memories need no clearing.
// A waiting result does not stall input unless another name finishes.
module identifier_scanner_symbol_intern #(
    parameter int TABLE_DEPTH  = isi_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_NAME_LEN = isi_pkg::MAX_NAME_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] char_code
    input  logic        s_tuser,  // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [7:0] symbol_id, [8] is_new, [9] table_full,
                                  // [10] name_truncated, [16:11] name_length
);

    isi_pkg::isi_cmd_t cmd;
    isi_pkg::isi_sts_t sts;

    isi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    isi_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .char_code    (s_tdata),
        .end_of_input (s_tuser),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

endmodule
